/* src/hsl2rgb_pkg.sv */
// Shared types for the HSL to RGB converter.
package hsl2rgb_pkg;

  // Control bits that travel alongside each item in the pipeline
  typedef struct packed {
    logic valid;  // stage holds a live item
    logic grey;   // saturation was zero: all channels take lightness
  } ctl_t;

endpackage

/* src/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB converter: front pipeline and three channel lanes.
//
//  port group                      | dir | handshake
//  --------------------------------+-----+--------------------------------------
//  hue, saturation, lightness      | in  | taken on a clock edge with start high
//                                  |     | and busy low
//  red, green, blue                | out | valid for the one cycle strobe is high
//
//  One item per clock. Four front stages (product, division by full scale, q, p)
//  feed three lanes of three stages (segment select, multiply, round/saturate).
//  busy is held low: the pipeline never stalls, and the receiver cannot stall it.
//  Synchronous reset clears the valid bits only; items in flight are dropped.
module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] hue,
  input  logic [CHANNEL_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS-1:0] lightness,
  output logic                    strobe,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue
);

  localparam int W = CHANNEL_BITS;

  ctl_t         ctl_pq;
  logic [W-1:0] p_pq, q_pq, l_pq;
  logic [W-1:0] t_r, t_g, t_b;
  logic         valid_r, valid_g, valid_b;

  assign busy = 1'b0;

  // Shared front pipeline
  hsl2rgb_pq #(
    .CHANNEL_BITS(W)
  ) u_pq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .ctl_out    (ctl_pq),
    .p_out      (p_pq),
    .q_out      (q_pq),
    .l_out      (l_pq),
    .t_red      (t_r),
    .t_green    (t_g),
    .t_blue     (t_b)
  );

  // Channel lanes
  hsl2rgb_ramp #(
    .CHANNEL_BITS(W)
  ) u_red (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_pq),
    .p         (p_pq),
    .q         (q_pq),
    .l         (l_pq),
    .t         (t_r),
    .valid_out (valid_r),
    .value     (red)
  );

  hsl2rgb_ramp #(
    .CHANNEL_BITS(W)
  ) u_green (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_pq),
    .p         (p_pq),
    .q         (q_pq),
    .l         (l_pq),
    .t         (t_g),
    .valid_out (valid_g),
    .value     (green)
  );

  hsl2rgb_ramp #(
    .CHANNEL_BITS(W)
  ) u_blue (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_pq),
    .p         (p_pq),
    .q         (q_pq),
    .l         (l_pq),
    .t         (t_b),
    .valid_out (valid_b),
    .value     (blue)
  );

  assign strobe = valid_r;

  // Lanes run in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (valid_r == valid_g) && (valid_r == valid_b))
    else $error("channel lanes out of step");

  // Every result comes from an item that was taken earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start, 7))
    else $error("result without a matching item");

  // Zero saturation gives grey at the item's lightness
  a_grey: assert property (@(posedge clk) disable iff (rst)
    strobe && ($past(saturation, 7) == '0) |->
      (red == $past(lightness, 7)) && (green == red) && (blue == red))
    else $error("grey item not passed through");

endmodule

/* src/hsl2rgb_pq.sv */
// Front pipeline: l*s product, rounded division by full scale, q and p, ramp positions.
module hsl2rgb_pq
  import hsl2rgb_pkg::*;
#(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [CHANNEL_BITS-1:0] hue,
  input  logic [CHANNEL_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS-1:0] lightness,
  output ctl_t                    ctl_out,
  output logic [CHANNEL_BITS-1:0] p_out,
  output logic [CHANNEL_BITS-1:0] q_out,
  output logic [CHANNEL_BITS-1:0] l_out,
  output logic [CHANNEL_BITS-1:0] t_red,
  output logic [CHANNEL_BITS-1:0] t_green,
  output logic [CHANNEL_BITS-1:0] t_blue
);

  localparam int W = CHANNEL_BITS;
  localparam logic [W-1:0]   FULL  = {W{1'b1}};
  localparam logic [2*W-1:0] HALF  = (2*W)'(1) << (W - 1);
  localparam logic [W-1:0]   THIRD = W'(((64'd1 << W) + 64'd1) / 64'd3);

  // Stage registers
  ctl_t             c1, c2, c3, c4;
  logic [W-1:0]     h1, s1, l1;
  logic [2*W-1:0]   prod1;
  logic [W-1:0]     s2, l2, ls2;
  logic [W-1:0]     tr2, tg2, tb2;
  logic [W-1:0]     l3, q3;
  logic [W-1:0]     tr3, tg3, tb3;
  logic [W-1:0]     l4, q4, p4;
  logic [W-1:0]     tr4, tg4, tb4;

  // Combinational terms
  logic [2*W-1:0]   x_round;
  logic [2*W:0]     x_sum;
  logic [W-1:0]     ls_next;
  logic [W:0]       lsum;
  logic [W:0]       q_wide;
  logic [W-1:0]     q_next;
  logic [W:0]       two_l;
  logic [W:0]       p_wide;
  logic [W-1:0]     p_next;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
    end else begin
      c1 <= '{valid: in_valid, grey: (saturation == '0)};
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
    end
  end

  // Stage 1: l*s
  always_ff @(posedge clk) begin
    h1    <= hue;
    s1    <= saturation;
    l1    <= lightness;
    prod1 <= (2*W)'(lightness) * (2*W)'(saturation);
  end

  // Stage 2: divide rounded product by 2^W-1 (exact for x below 2^2W-1)
  always_comb begin
    x_round = prod1 + HALF;
    x_sum   = {1'b0, x_round} + (2*W+1)'(x_round >> W) + (2*W+1)'(1);
    ls_next = x_sum[W +: W];
  end

  always_ff @(posedge clk) begin
    s2  <= s1;
    l2  <= l1;
    ls2 <= ls_next;
    tr2 <= h1 + THIRD;
    tg2 <= h1;
    tb2 <= h1 - THIRD;
  end

  // Stage 3: q, saturated to full scale
  always_comb begin
    lsum = {1'b0, l2} + {1'b0, s2};
    if (!l2[W-1]) begin
      q_wide = {1'b0, l2} + {1'b0, ls2};
    end else if (lsum > {1'b0, ls2}) begin
      q_wide = lsum - {1'b0, ls2};
    end else begin
      q_wide = '0;
    end
    q_next = q_wide[W] ? FULL : q_wide[W-1:0];
  end

  always_ff @(posedge clk) begin
    l3  <= l2;
    q3  <= q_next;
    tr3 <= tr2;
    tg3 <= tg2;
    tb3 <= tb2;
  end

  // Stage 4: p = 2l - q, floored at zero and capped at q
  always_comb begin
    two_l  = {l3, 1'b0};
    p_wide = (two_l > {1'b0, q3}) ? (two_l - {1'b0, q3}) : '0;
    p_next = (p_wide > {1'b0, q3}) ? q3 : p_wide[W-1:0];
  end

  always_ff @(posedge clk) begin
    l4  <= l3;
    q4  <= q3;
    p4  <= p_next;
    tr4 <= tr3;
    tg4 <= tg3;
    tb4 <= tb3;
  end

  assign ctl_out = c4;
  assign p_out   = p4;
  assign q_out   = q4;
  assign l_out   = l4;
  assign t_red   = tr4;
  assign t_green = tg4;
  assign t_blue  = tb4;

  // p never above lightness, lightness never above q
  a_p_le_l: assert property (@(posedge clk) disable iff (rst)
    c4.valid |-> (p4 <= l4))
    else $error("p above lightness");

  a_l_le_q: assert property (@(posedge clk) disable iff (rst)
    c4.valid |-> (l4 <= q4))
    else $error("lightness above q");

endmodule

/* src/hsl2rgb_ramp.sv */
// One channel lane: hue ramp segment select, span multiply, rounding and saturation.
module hsl2rgb_ramp
  import hsl2rgb_pkg::*;
#(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    ctl_in,
  input  logic [CHANNEL_BITS-1:0] p,
  input  logic [CHANNEL_BITS-1:0] q,
  input  logic [CHANNEL_BITS-1:0] l,
  input  logic [CHANNEL_BITS-1:0] t,
  output logic                    valid_out,
  output logic [CHANNEL_BITS-1:0] value
);

  localparam int W = CHANNEL_BITS;
  localparam logic [W-1:0]   FULL   = {W{1'b1}};
  localparam logic [W+2:0]   ONE_X  = (W+3)'(1) << W;
  localparam logic [W+2:0]   FOUR_X = (W+3)'(1) << (W + 2);
  localparam logic [W+1:0]   TWO_X  = (W+2)'(1) << (W + 1);
  localparam logic [2*W:0]   HALF   = (2*W+1)'(1) << (W - 1);

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // Stage registers
  ctl_t          ca, cb;
  seg_t          seg_a, seg_b;
  logic [W:0]    frac_a;
  logic [W-1:0]  span_a;
  logic [W-1:0]  p_a, q_a, l_a;
  logic [2*W:0]  prod_b;
  logic [W-1:0]  p_b, q_b, l_b;
  logic          valid_c;
  logic [W-1:0]  value_c;

  // Combinational terms
  logic [W+2:0]  six_t;
  logic [W+1:0]  three_t;
  logic [W+2:0]  fall_x;
  seg_t          seg_next;
  logic [W:0]    frac_next;
  logic [2*W:0]  rnd;
  logic [W:0]    v_wide;
  logic [W-1:0]  v_sat;
  logic [W-1:0]  value_next;

  // Control chain
  always_ff @(posedge clk) begin
    if (rst) begin
      ca      <= '0;
      cb      <= '0;
      valid_c <= 1'b0;
    end else begin
      ca      <= ctl_in;
      cb      <= ca;
      valid_c <= cb.valid;
    end
  end

  // Stage A: pick the ramp segment from the position
  always_comb begin
    six_t   = (W+3)'({t, 2'b00}) + (W+3)'({t, 1'b0});
    three_t = (W+2)'({t, 1'b0}) + (W+2)'(t);
    fall_x  = FOUR_X - six_t;
    priority if (six_t < ONE_X) begin
      seg_next  = SEG_RISE;
      frac_next = six_t[W:0];
    end else if (!t[W-1]) begin
      seg_next  = SEG_HIGH;
      frac_next = '0;
    end else if (three_t < TWO_X) begin
      seg_next  = SEG_FALL;
      frac_next = fall_x[W:0];
    end else begin
      seg_next  = SEG_LOW;
      frac_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    seg_a  <= seg_next;
    frac_a <= frac_next;
    span_a <= q - p;
    p_a    <= p;
    q_a    <= q;
    l_a    <= l;
  end

  // Stage B: span times fraction
  always_ff @(posedge clk) begin
    seg_b  <= seg_a;
    prod_b <= (2*W+1)'(frac_a) * (2*W+1)'(span_a);
    p_b    <= p_a;
    q_b    <= q_a;
    l_b    <= l_a;
  end

  // Stage C: round, add p, saturate, choose; grey items take lightness
  always_comb begin
    rnd    = prod_b + HALF;
    v_wide = {1'b0, p_b} + (W+1)'(rnd >> W);
    v_sat  = v_wide[W] ? FULL : v_wide[W-1:0];
    unique case (seg_b)
      SEG_RISE, SEG_FALL: value_next = v_sat;
      SEG_HIGH:           value_next = q_b;
      SEG_LOW:            value_next = p_b;
      default:            value_next = p_b;
    endcase
    if (cb.grey) begin
      value_next = l_b;
    end
  end

  always_ff @(posedge clk) begin
    value_c <= value_next;
  end

  assign valid_out = valid_c;
  assign value     = value_c;

  // Flat segments need no product
  a_flat_frac: assert property (@(posedge clk) disable iff (rst)
    ca.valid && (seg_a == SEG_HIGH || seg_a == SEG_LOW) |-> (frac_a == '0))
    else $error("flat segment with nonzero fraction");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the HSL to RGB converter: directed and random colours.
`timescale 1ns / 100ps

module testbench;

  localparam int CH_BITS = 16;
  localparam bit [63:0] FULL = 64'd1 << CH_BITS;
  localparam bit [63:0] MAXV = FULL - 64'd1;
  localparam bit [63:0] HALF = 64'd1 << (CH_BITS - 1);
  localparam bit [63:0] THIRD = (FULL + 64'd1) / 64'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 100000;

  typedef logic [CH_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t      hue;
    chan_t      sat;
    chan_t      light;
    logic [6:0] gap_pct;
  } hsl_item_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  chan_t hue = '0;
  chan_t saturation = '0;
  chan_t lightness = '0;
  logic  strobe;
  chan_t red;
  chan_t green;
  chan_t blue;

  hsl_item_t pending_hsl[$];
  rgb_t      expected_rgb[$];
  int        total_items = 0;
  int        accepted_count = 0;
  int        errors = 0;
  int        cycles = 0;

  hsl_to_rgb_converter #(
    .CHANNEL_BITS(CH_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .hue       (hue),
    .saturation(saturation),
    .lightness (lightness),
    .strobe    (strobe),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Piecewise-linear hue ramp between p and q at turn position t
  function automatic bit [63:0] ramp_level(bit [63:0] p, bit [63:0] q, bit [63:0] t);
    bit [63:0] frac;
    bit [63:0] v;
    if (6 * t < FULL) begin
      frac = 6 * t;
    end else if (2 * t < FULL) begin
      return q;
    end else if (3 * t < 2 * FULL) begin
      frac = 4 * FULL - 6 * t;
    end else begin
      return p;
    end
    v = p + (((q - p) * frac + HALF) >> CH_BITS);
    return (v > MAXV) ? MAXV : v;
  endfunction

  // Expected colour for one HSL item
  function automatic rgb_t convert_hsl(chan_t h_in, chan_t s_in, chan_t l_in);
    bit [63:0] h, s, l, ls, q, p;
    rgb_t c;
    h = h_in;
    s = s_in;
    l = l_in;
    if (s == 0) begin
      c.red = l_in;
      c.green = l_in;
      c.blue = l_in;
      return c;
    end
    ls = (l * s + HALF) / MAXV;
    if (2 * l < MAXV) q = l + ls;
    else q = (l + s > ls) ? (l + s - ls) : 64'd0;
    if (q > MAXV) q = MAXV;
    p = (2 * l > q) ? (2 * l - q) : 64'd0;
    if (p > q) p = q;
    c.red   = CH_BITS'(ramp_level(p, q, (h + THIRD) & MAXV));
    c.green = CH_BITS'(ramp_level(p, q, h));
    c.blue  = CH_BITS'(ramp_level(p, q, (h + FULL - THIRD) & MAXV));
    return c;
  endfunction

  task automatic queue_colour(chan_t h, chan_t s, chan_t l, int gap);
    hsl_item_t it;
    it.hue = h;
    it.sat = s;
    it.light = l;
    it.gap_pct = 7'(gap);
    pending_hsl.push_back(it);
    total_items++;
  endtask

  // Channel value biased towards the extremes and mid-scale
  function automatic chan_t pick_level();
    int sel;
    sel = $urandom_range(15);
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return chan_t'($urandom_range(3));
      3:       return chan_t'(MAXV - $urandom_range(3));
      4:       return chan_t'(HALF - 2 + $urandom_range(3));
      default: return chan_t'($urandom);
    endcase
  endfunction

  // Hue biased towards the ramp segment boundaries of all three channels
  function automatic chan_t pick_hue();
    bit [63:0] edges[6];
    edges = '{64'h0, 64'h2AAB, 64'h5555, 64'h8000, 64'hAAAB, 64'hD555};
    if ($urandom_range(3) == 0)
      return chan_t'(edges[$urandom_range(5)] + FULL - 3 + $urandom_range(6));
    return chan_t'($urandom);
  endfunction

  // Driver: presents the next pending item once the current one has been taken
  always @(posedge clk) begin : driver
    bit        accepted;
    bit        give;
    hsl_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        expected_rgb.push_back(convert_hsl(hue, saturation, lightness));
        accepted_count++;
      end
      if (accepted || !start) begin
        give = (pending_hsl.size() != 0) && ($urandom_range(99) >= pending_hsl[0].gap_pct);
        if (give) begin
          nxt = pending_hsl.pop_front();
          hue <= nxt.hue;
          saturation <= nxt.sat;
          lightness <= nxt.light;
        end else begin
          // junk on the fields while idle; must be ignored
          hue <= chan_t'($urandom);
          saturation <= chan_t'($urandom);
          lightness <= chan_t'($urandom);
        end
        start <= give;
      end
    end
  end

  task automatic report_mismatch(string what, chan_t got, chan_t want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    errors++;
  endtask

  // Monitor: every strobed colour against the oldest expectation
  always @(posedge clk) begin : monitor
    rgb_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_rgb.size() == 0) begin
        $display("unexpected colour at cycle %0d: %h %h %h", cycles, red, green, blue);
        errors++;
      end else begin
        want = expected_rgb.pop_front();
        if (red !== want.red) report_mismatch("red", red, want.red);
        if (green !== want.green) report_mismatch("green", green, want.green);
        if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int gap;
    int sel;
    chan_t s;

    // directed: extremes, grey, the q branch split and ramp segment edges
    queue_colour('0, '0, '0, 28);
    queue_colour('1, '1, '1, 28);
    queue_colour(16'h1234, '0, 16'h8000, 28);
    queue_colour('1, '0, '1, 28);
    queue_colour(16'h5555, '0, 16'h0001, 28);
    queue_colour(16'h0000, '1, 16'h8000, 28);
    queue_colour(16'h5555, '1, 16'h8000, 28);
    queue_colour(16'hAAAA, '1, 16'h8000, 28);
    queue_colour(16'h0000, '1, 16'h7FFF, 28);
    queue_colour(16'h0000, '1, 16'h7FFE, 28);
    queue_colour(16'h2AAA, '1, 16'h8000, 28);
    queue_colour(16'h2AAB, '1, 16'h8000, 28);
    queue_colour(16'h7FFF, '1, 16'h8000, 28);
    queue_colour(16'h8000, '1, 16'h8000, 28);
    queue_colour(16'hAAAA, 16'h0001, 16'hFFFE, 28);
    queue_colour(16'hAAAB, '1, 16'h4000, 28);
    queue_colour(16'hD555, '1, 16'hC000, 28);
    queue_colour('1, '1, 16'h0001, 28);
    queue_colour(16'h1000, '1, '1, 28);
    queue_colour(16'h1000, 16'h0001, 16'h0001, 28);
    queue_colour(16'h9999, 16'h8000, 16'h3333, 28);
    queue_colour(16'hFFFF, 16'hFFFF, 16'h0000, 28);

    // random phases: no gaps, heavy gaps, no gaps, light gaps
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i * 4 / RANDOM_ITEMS)
        0:       gap = 0;
        1:       gap = 54;
        2:       gap = 0;
        default: gap = 28;
      endcase
      sel = $urandom_range(9);
      s = (sel == 0) ? chan_t'(0) : pick_level();
      queue_colour(pick_hue(), s, pick_level(), gap);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count != total_items) @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    errors += expected_rgb.size();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
